### src/lasi_pkg.sv
// Shared types, codes and helpers for the line/arc step interpolator.
package lasi_pkg;

  localparam int COORD_BITS = 24;
  localparam int STEP_BITS  = COORD_BITS + 2;
  localparam int RAD_BITS   = 2 * COORD_BITS + 1;
  localparam int DEV_BITS   = 32;

  localparam logic [1:0] CMD_LINE = 2'd0;
  localparam logic [1:0] CMD_ARC  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BUSY      = 2'd1;
  localparam logic [1:0] ST_RADIUS    = 2'd2;
  localparam logic [1:0] ST_IDLE_TICK = 2'd3;

  localparam logic [1:0] QUAD_1 = 2'd0;
  localparam logic [1:0] QUAD_2 = 2'd1;
  localparam logic [1:0] QUAD_3 = 2'd2;
  localparam logic [1:0] QUAD_4 = 2'd3;

  typedef struct packed {
    logic [1:0]                   cmd;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic                         arc_ccw;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       step_valid;
    logic       step_axis;
    logic       step_positive;
    logic       done_res;
  } out_item_t;

  // Request held in the input stage, with both squared radii precomputed.
  typedef struct packed {
    in_item_t            item;
    logic [RAD_BITS-1:0] rad_start;
    logic [RAD_BITS-1:0] rad_target;
  } s1_item_t;

  function automatic logic [DEV_BITS-1:0] coord_sext(input logic [COORD_BITS-1:0] v);
    coord_sext = {{(DEV_BITS - COORD_BITS){v[COORD_BITS-1]}}, v};
  endfunction

  function automatic logic [DEV_BITS-1:0] coord_zext(input logic [COORD_BITS-1:0] v);
    coord_zext = {{(DEV_BITS - COORD_BITS){1'b0}}, v};
  endfunction

endpackage

### src/lasi_in_stage.sv
// Input register: captures a request and the squared start and end radii.
module lasi_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  lasi_pkg::in_item_t   in_data,
  input  logic                 advance,
  output logic                 s1_vld,
  output lasi_pkg::s1_item_t   s1_data
);

  localparam int CB = lasi_pkg::COORD_BITS;

  logic                 s1_vld_r;
  lasi_pkg::s1_item_t   s1_data_r;
  lasi_pkg::s1_item_t   s1_data_nxt;
  logic signed [2*CB-1:0] sq_sx, sq_sy, sq_tx, sq_ty;
  logic                 accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    sq_sx = in_data.start_x * in_data.start_x;
    sq_sy = in_data.start_y * in_data.start_y;
    sq_tx = in_data.target_x * in_data.target_x;
    sq_ty = in_data.target_y * in_data.target_y;
    s1_data_nxt.item       = in_data;
    s1_data_nxt.rad_start  = {1'b0, sq_sx} + {1'b0, sq_sy};
    s1_data_nxt.rad_target = {1'b0, sq_tx} + {1'b0, sq_ty};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (accept) begin
      s1_vld_r <= 1'b1;
    end else if (advance) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r <= s1_data_nxt;
    end
  end

  assign s1_vld  = s1_vld_r;
  assign s1_data = s1_data_r;

endmodule

### src/lasi_engine.sv
// Interpolator state and per-request step logic (line and arc comparison method).
module lasi_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  lasi_pkg::s1_item_t   s1_data,
  output lasi_pkg::out_item_t  res
);

  localparam int CB = lasi_pkg::COORD_BITS;
  localparam int SB = lasi_pkg::STEP_BITS;
  localparam int DW = lasi_pkg::DEV_BITS;

  typedef struct packed {
    logic          axis;
    logic [DW-1:0] dev;
  } choice_t;

  logic          busy_r, busy_nxt;
  logic          arc_mode_r, arc_mode_nxt;
  logic          arc_dir_r, arc_dir_nxt;
  logic [1:0]    quad_r, quad_nxt;
  logic [1:0]    axis_neg_r, axis_neg_nxt;
  logic          axis_r, axis_nxt;
  logic [DW-1:0] dev_r, dev_nxt;
  logic [SB-1:0] steps_r, steps_nxt;
  logic [CB-1:0] pos_x_r, pos_x_nxt;
  logic [CB-1:0] pos_y_r, pos_y_nxt;
  logic [CB-1:0] end_x_r, end_x_nxt;
  logic [CB-1:0] end_y_r, end_y_nxt;

  lasi_pkg::in_item_t item;
  logic [CB-1:0]  abs_tx, abs_ty;
  logic [CB:0]    diff_x, diff_y, adiff_x, adiff_y;
  logic           sx_pos, sx_neg, sx_zero, sy_pos, sy_neg, sy_zero;
  logic [1:0]     arc_quad;
  logic [1:0]     arc_neg;
  logic           arc_axis0;
  logic [CB-1:0]  step_pos, step_pos_nxt;
  logic           dev_neg, odd_pair, pick_x;
  choice_t        line_start_c, line_tick_c;

  function automatic choice_t line_choose(input logic [DW-1:0] dev,
                                          input logic [CB-1:0] ex,
                                          input logic [CB-1:0] ey);
    choice_t c;
    if (dev != '0 && !dev[DW-1]) begin
      c.axis = 1'b0;
      c.dev  = dev - lasi_pkg::coord_zext(ey);
    end else if (dev[DW-1] || ey > ex) begin
      c.axis = 1'b1;
      c.dev  = dev + lasi_pkg::coord_zext(ex);
    end else begin
      c.axis = 1'b0;
      c.dev  = dev - lasi_pkg::coord_zext(ey);
    end
    return c;
  endfunction

  // Add 2*s*p + 1 to the deviation.
  function automatic logic [DW-1:0] arc_term(input logic [DW-1:0] dev,
                                             input logic [CB-1:0] p,
                                             input logic neg);
    logic [DW-1:0] twice;
    twice = lasi_pkg::coord_sext(p) << 1;
    return (neg ? dev - twice : dev + twice) + {{(DW-1){1'b0}}, 1'b1};
  endfunction

  assign item = s1_data.item;

  always_comb begin
    abs_tx  = item.target_x[CB-1] ? -item.target_x : item.target_x;
    abs_ty  = item.target_y[CB-1] ? -item.target_y : item.target_y;
    diff_x  = {item.target_x[CB-1], item.target_x} - {item.start_x[CB-1], item.start_x};
    diff_y  = {item.target_y[CB-1], item.target_y} - {item.start_y[CB-1], item.start_y};
    adiff_x = diff_x[CB] ? -diff_x : diff_x;
    adiff_y = diff_y[CB] ? -diff_y : diff_y;
    sx_neg  = item.start_x[CB-1];
    sx_zero = item.start_x == '0;
    sx_pos  = !sx_neg && !sx_zero;
    sy_neg  = item.start_y[CB-1];
    sy_zero = item.start_y == '0;
    sy_pos  = !sy_neg && !sy_zero;
    line_start_c = line_choose('0, abs_tx, abs_ty);
  end

  // Quadrant and step directions; points on an axis go with the motion leaving them.
  always_comb begin
    if (item.arc_ccw) begin
      if (sx_pos) begin
        if (!sy_neg) begin arc_quad = lasi_pkg::QUAD_1; arc_neg = 2'b01; end
        else         begin arc_quad = lasi_pkg::QUAD_4; arc_neg = 2'b00; end
      end else if (sx_neg) begin
        if (!sy_pos) begin arc_quad = lasi_pkg::QUAD_3; arc_neg = 2'b10; end
        else         begin arc_quad = lasi_pkg::QUAD_2; arc_neg = 2'b11; end
      end else begin
        if (sy_pos)  begin arc_quad = lasi_pkg::QUAD_2; arc_neg = 2'b11; end
        else         begin arc_quad = lasi_pkg::QUAD_4; arc_neg = 2'b00; end
      end
    end else begin
      if (sx_pos) begin
        if (sy_pos)  begin arc_quad = lasi_pkg::QUAD_1; arc_neg = 2'b10; end
        else         begin arc_quad = lasi_pkg::QUAD_4; arc_neg = 2'b11; end
      end else if (sx_neg) begin
        if (sy_neg)  begin arc_quad = lasi_pkg::QUAD_3; arc_neg = 2'b01; end
        else         begin arc_quad = lasi_pkg::QUAD_2; arc_neg = 2'b00; end
      end else begin
        if (sy_pos)  begin arc_quad = lasi_pkg::QUAD_1; arc_neg = 2'b10; end
        else         begin arc_quad = lasi_pkg::QUAD_3; arc_neg = 2'b01; end
      end
    end
    arc_axis0 = !sx_zero;
  end

  // Tick path: step the active axis, then pick the next one.
  always_comb begin
    step_pos     = axis_r ? pos_y_r : pos_x_r;
    step_pos_nxt = axis_neg_r[axis_r] ? step_pos - 1'b1 : step_pos + 1'b1;
    dev_neg      = dev_r[DW-1];
    odd_pair     = (quad_r == lasi_pkg::QUAD_2) || (quad_r == lasi_pkg::QUAD_4);
    if (arc_dir_r) begin
      pick_x = dev_neg ? odd_pair : !odd_pair;
    end else begin
      pick_x = dev_neg ? !odd_pair : odd_pair;
    end
    line_tick_c = line_choose(dev_r, end_x_r, end_y_r);
  end

  always_comb begin
    busy_nxt     = busy_r;
    arc_mode_nxt = arc_mode_r;
    arc_dir_nxt  = arc_dir_r;
    quad_nxt     = quad_r;
    axis_neg_nxt = axis_neg_r;
    axis_nxt     = axis_r;
    dev_nxt      = dev_r;
    steps_nxt    = steps_r;
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    end_x_nxt    = end_x_r;
    end_y_nxt    = end_y_r;
    res          = '0;
    case (item.cmd)
      lasi_pkg::CMD_LINE, lasi_pkg::CMD_ARC: begin
        if (busy_r) begin
          res.status = lasi_pkg::ST_BUSY;
        end else if (item.cmd == lasi_pkg::CMD_ARC &&
                     s1_data.rad_start != s1_data.rad_target) begin
          res.status = lasi_pkg::ST_RADIUS;
        end else if (item.cmd == lasi_pkg::CMD_LINE) begin
          arc_mode_nxt = 1'b0;
          axis_neg_nxt = {item.target_y[CB-1], item.target_x[CB-1]};
          end_x_nxt    = abs_tx;
          end_y_nxt    = abs_ty;
          pos_x_nxt    = '0;
          pos_y_nxt    = '0;
          steps_nxt    = {2'b00, abs_tx} + {2'b00, abs_ty};
          axis_nxt     = line_start_c.axis;
          dev_nxt      = line_start_c.dev;
          busy_nxt     = steps_nxt != '0;
        end else begin
          arc_mode_nxt = 1'b1;
          arc_dir_nxt  = item.arc_ccw;
          pos_x_nxt    = item.start_x;
          pos_y_nxt    = item.start_y;
          quad_nxt     = arc_quad;
          axis_neg_nxt = arc_neg;
          steps_nxt    = {1'b0, adiff_x} + {1'b0, adiff_y};
          axis_nxt     = arc_axis0;
          dev_nxt      = arc_term('0, arc_axis0 ? item.start_y : item.start_x,
                                  arc_neg[arc_axis0]);
          busy_nxt     = steps_nxt != '0;
        end
      end
      lasi_pkg::CMD_TICK: begin
        if (!busy_r) begin
          res.status = lasi_pkg::ST_IDLE_TICK;
        end else begin
          res.step_valid    = 1'b1;
          res.step_axis     = axis_r;
          res.step_positive = !axis_neg_r[axis_r];
          if (axis_r) begin
            pos_y_nxt = step_pos_nxt;
          end else begin
            pos_x_nxt = step_pos_nxt;
          end
          if (arc_mode_r) begin
            axis_nxt = !pick_x;
            dev_nxt  = arc_term(dev_r, pick_x ? pos_x_nxt : pos_y_nxt, axis_neg_r[!pick_x]);
          end else begin
            axis_nxt = line_tick_c.axis;
            dev_nxt  = line_tick_c.dev;
          end
          steps_nxt = steps_r - 1'b1;
          if (steps_nxt == '0) begin
            busy_nxt     = 1'b0;
            res.done_res = 1'b1;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      arc_mode_r <= 1'b0;
      arc_dir_r  <= 1'b0;
      quad_r     <= lasi_pkg::QUAD_1;
      axis_neg_r <= 2'b00;
      axis_r     <= 1'b0;
      dev_r      <= '0;
      steps_r    <= '0;
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      end_x_r    <= '0;
      end_y_r    <= '0;
    end else if (fire) begin
      busy_r     <= busy_nxt;
      arc_mode_r <= arc_mode_nxt;
      arc_dir_r  <= arc_dir_nxt;
      quad_r     <= quad_nxt;
      axis_neg_r <= axis_neg_nxt;
      axis_r     <= axis_nxt;
      dev_r      <= dev_nxt;
      steps_r    <= steps_nxt;
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      end_x_r    <= end_x_nxt;
      end_y_r    <= end_y_nxt;
    end
  end

  a_busy_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> steps_r != '0)
    else $error("busy with no steps left");

  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(!rst_n) || $past(fire && res.done_res))
    else $error("move ended without a final step");

  a_busy_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.status == lasi_pkg::ST_BUSY |=> busy_r && $stable(steps_r))
    else $error("rejected start changed the move");

  a_done_is_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.done_res |-> res.step_valid && steps_r == {{(SB-1){1'b0}}, 1'b1})
    else $error("final step mark on a non-final step");

endmodule

### src/line_arc_step_interpolator_core.sv
// Top level of the line/arc step interpolator: handshake, pipeline control, result register.
//
// Two-axis point-by-point comparison interpolator. A line or arc start
// request loads a move; each tick request returns one step (axis,
// direction, final-step mark). Every request yields exactly one result.
// Throughput is one request per clock while out_ready does not hold the
// pipeline. The input register captures an accepted request with its
// squared start and end radii, and the state update loads the result
// register from it. The move state is updated from its own registers, so
// ticks follow each other without gaps. in_ready drops only when both
// the input register and the result register are full and out_ready is
// low.
module line_arc_step_interpolator_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lasi_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lasi_pkg::out_item_t  out_data
);

  logic                 advance;
  logic                 s1_vld;
  lasi_pkg::s1_item_t   s1_data;
  lasi_pkg::out_item_t  res_c;
  logic                 out_vld_r;
  lasi_pkg::out_item_t  out_data_r;

  // Move the pipeline whenever the result register is free or being drained.
  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !s1_vld || advance;

  lasi_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .s1_vld   (s1_vld),
    .s1_data  (s1_data)
  );

  lasi_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance && s1_vld),
    .s1_data (s1_data),
    .res     (res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_vld) begin
      out_data_r <= res_c;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
